// File: rtl/core/cave_automaton_generation_defines.svh
// Assertion helpers used by the checker file cag_checker.sv.
`ifndef CAVE_AUTOMATON_GENERATION_DEFINES_SVH
`define CAVE_AUTOMATON_GENERATION_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define CAG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cave automaton check failed");

// Next-cycle implication, held off while reset is asserted.
`define CAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cave automaton check failed");

`endif

// File: rtl/core/cag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cag_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int COUNTER_SPAN   = 4096;

    localparam int GW_W       = 7;
    localparam int GH_W       = 13;
    localparam int LIM_W      = 4;
    localparam int ROWNUM_W   = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int NCNT_W     = 4;

    localparam logic [GW_W-1:0]  RESET_WIDTH  = 7'd64;
    localparam logic [GH_W-1:0]  RESET_HEIGHT = 13'd64;
    localparam logic [LIM_W-1:0] RESET_DEATH  = 4'd2;
    localparam logic [LIM_W-1:0] RESET_BIRTH  = 4'd3;
    localparam logic [GW_W-1:0]  MIN_WIDTH    = 7'd3;
    localparam logic [GH_W-1:0]  MIN_HEIGHT   = 13'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_DEATH_LIMIT = 2'd2,
        CFG_BIRTH_LIMIT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [ROWNUM_W-1:0] row_number;
        logic                last_of_run;
        logic                frame_end;
    } meta_t;

endpackage

`default_nettype wire

// File: rtl/core/cag_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module cag_lane (
    input  wire logic [2:0]                up,
    input  wire logic [2:0]                mid,
    input  wire logic [2:0]                dn,
    input  wire logic [cag_pkg::LIM_W-1:0] death_limit,
    input  wire logic [cag_pkg::LIM_W-1:0] birth_limit,
    output logic                           rock
);
    import cag_pkg::*;

    logic [NCNT_W-1:0] count;

    always_comb
    begin
        count = NCNT_W'(up[0]) + NCNT_W'(up[1]) + NCNT_W'(up[2])
              + NCNT_W'(mid[0]) + NCNT_W'(mid[2])
              + NCNT_W'(dn[0]) + NCNT_W'(dn[1]) + NCNT_W'(dn[2]);
        if (mid[1])
            rock = (count >= death_limit);
        else
            rock = (count > birth_limit);
    end

endmodule

`default_nettype wire

// File: rtl/core/cag_row_gen.sv
`timescale 1ns / 1ps
`default_nettype none

module cag_row_gen #(
    parameter int MAX_WIDTH = cag_pkg::DEF_MAX_WIDTH
) (
    input  wire logic [MAX_WIDTH-1:0]      older_row,
    input  wire logic [MAX_WIDTH-1:0]      newer_row,
    input  wire logic [MAX_WIDTH-1:0]      cur_row,
    input  wire logic [cag_pkg::GW_W-1:0]  width_eff,
    input  wire logic [cag_pkg::LIM_W-1:0] death_limit,
    input  wire logic [cag_pkg::LIM_W-1:0] birth_limit,
    input  wire logic                      first_row,
    output logic [MAX_WIDTH-1:0]           next_row,
    output logic [MAX_WIDTH-1:0]           mask
);
    import cag_pkg::*;

    logic [MAX_WIDTH-1:0] above;
    logic [MAX_WIDTH-1:0] middle;
    logic [MAX_WIDTH-1:0] below;
    logic [MAX_WIDTH-1:0] lane_rock;

    always_comb
    begin
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            mask[x] = (GW_W'(x) < width_eff);
        end
    end

    assign above  = older_row & mask;
    assign middle = newer_row & mask;
    assign below  = cur_row & mask;

    for (genvar x = 0; x < MAX_WIDTH; x++)
    begin : g_lane
        logic [2:0] up_w;
        logic [2:0] mid_w;
        logic [2:0] dn_w;

        if (x == 0)
        begin : g_left
            assign up_w[0]  = 1'b0;
            assign mid_w[0] = 1'b0;
            assign dn_w[0]  = 1'b0;
        end
        else
        begin : g_left
            assign up_w[0]  = above[x-1];
            assign mid_w[0] = middle[x-1];
            assign dn_w[0]  = below[x-1];
        end

        if (x == MAX_WIDTH - 1)
        begin : g_right
            assign up_w[2]  = 1'b0;
            assign mid_w[2] = 1'b0;
            assign dn_w[2]  = 1'b0;
        end
        else
        begin : g_right
            assign up_w[2]  = above[x+1];
            assign mid_w[2] = middle[x+1];
            assign dn_w[2]  = below[x+1];
        end

        assign up_w[1]  = above[x];
        assign mid_w[1] = middle[x];
        assign dn_w[1]  = below[x];

        cag_lane u_lane (
            .up          (up_w),
            .mid         (mid_w),
            .dn          (dn_w),
            .death_limit (death_limit),
            .birth_limit (birth_limit),
            .rock        (lane_rock[x])
        );
    end

    // merge: border columns and the top row are rock, cells past the width are zero
    always_comb
    begin
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            next_row[x] = mask[x] & (first_row | (x == 0) |
                          (GW_W'(x) == width_eff - GW_W'(1)) | lane_rock[x]);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cag_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cag_out_queue #(
    parameter int MAX_WIDTH = cag_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           push_cnt,
    input  wire logic [MAX_WIDTH-1:0] a_row,
    input  wire cag_pkg::meta_t       a_meta,
    input  wire logic [MAX_WIDTH-1:0] b_row,
    input  wire cag_pkg::meta_t       b_meta,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [MAX_WIDTH-1:0]      head_row,
    output cag_pkg::meta_t            head_meta,
    output logic [1:0]                level
);
    import cag_pkg::*;

    logic [MAX_WIDTH-1:0] row0_reg, row0_next;
    logic [MAX_WIDTH-1:0] row1_reg, row1_next;
    meta_t                meta0_reg, meta0_next;
    meta_t                meta1_reg, meta1_next;
    logic [1:0]           count_reg, count_next;
    logic                 pop;
    logic [1:0]           remain;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid & ~out_stall;
    assign remain    = count_reg - 2'(pop);

    always_comb
    begin
        row0_next  = row0_reg;
        row1_next  = row1_reg;
        meta0_next = meta0_reg;
        meta1_next = meta1_reg;
        case (remain)
            2'd0:
            begin
                row0_next  = a_row;
                meta0_next = a_meta;
                row1_next  = b_row;
                meta1_next = b_meta;
            end
            2'd1:
            begin
                if (pop)
                begin
                    row0_next  = row1_reg;
                    meta0_next = meta1_reg;
                end
                row1_next  = a_row;
                meta1_next = a_meta;
            end
            default:
            begin
                row0_next = row0_reg;
            end
        endcase
        count_next = remain + push_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row0_reg  <= row0_next;
        row1_reg  <= row1_next;
        meta0_reg <= meta0_next;
        meta1_reg <= meta1_next;
    end

    assign head_row  = row0_reg;
    assign head_meta = meta0_reg;
    assign level     = count_reg;

endmodule

`default_nettype wire

// File: rtl/core/cave_automaton_generation.sv
// Output: result beats are registered in the result queue and offered from its head.
// Throughput: one row per cycle while row_stall is low; a frame's last row yields two
// beats and is held off until both entries of the two-entry result queue are free.
// Rate is set by the 64 neighbor-count lanes working on one row per clock.
// Reset: asynchronous, active low; registers return to their defaults, row buffers
// clear, the row counter restarts at row zero and the result queue empties.
`timescale 1ns / 1ps
`default_nettype none

module cave_automaton_generation #(
    parameter int MAX_WIDTH  = cag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cag_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cag_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           row_valid,
    output logic                                row_stall,
    input  wire logic [MAX_WIDTH-1:0]           row_cells,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [MAX_WIDTH-1:0]                next_row_cells,
    output logic [cag_pkg::ROWNUM_W-1:0]        row_number,
    output logic                                last_of_run,
    output logic                                frame_end
);
    import cag_pkg::*;

    localparam int HSPAN = (MAX_HEIGHT < COUNTER_SPAN) ? MAX_HEIGHT : COUNTER_SPAN;
    localparam int CNT_W = $clog2(HSPAN);

    logic [GW_W-1:0]      grid_width_reg;
    logic [GH_W-1:0]      grid_height_reg;
    logic [LIM_W-1:0]     death_limit_reg;
    logic [LIM_W-1:0]     birth_limit_reg;
    logic [MAX_WIDTH-1:0] older_reg, older_next;
    logic [MAX_WIDTH-1:0] newer_reg, newer_next;
    logic [CNT_W-1:0]     row_cnt_reg, row_cnt_next;

    logic [GW_W-1:0]      width_eff;
    logic [CNT_W:0]       height_eff;
    logic [CNT_W:0]       cnt_plus1;
    logic                 last;
    logic                 has_first;
    logic [1:0]           need;
    logic [1:0]           level;
    logic                 accept;
    logic [1:0]           push_cnt;
    logic [MAX_WIDTH-1:0] gen_row;
    logic [MAX_WIDTH-1:0] mask;
    meta_t                first_meta;
    meta_t                last_meta;
    logic [MAX_WIDTH-1:0] a_row;
    meta_t                a_meta;
    meta_t                head_meta;

    always_comb
    begin
        if (grid_width_reg < MIN_WIDTH)
            width_eff = MIN_WIDTH;
        else if (grid_width_reg > GW_W'(MAX_WIDTH))
            width_eff = GW_W'(MAX_WIDTH);
        else
            width_eff = grid_width_reg;

        if (grid_height_reg < MIN_HEIGHT)
            height_eff = (CNT_W+1)'(MIN_HEIGHT);
        else if (grid_height_reg > GH_W'(HSPAN))
            height_eff = (CNT_W+1)'(HSPAN);
        else
            height_eff = grid_height_reg[CNT_W:0];
    end

    assign cnt_plus1 = {1'b0, row_cnt_reg} + (CNT_W+1)'(1);
    assign last      = (cnt_plus1 >= height_eff);
    assign has_first = (row_cnt_reg != CNT_W'(0));
    assign need      = 2'(has_first) + 2'(last);
    assign row_stall = ((3'(level) + 3'(need)) > 3'd2);
    assign accept    = row_valid & ~row_stall;
    assign push_cnt  = accept ? need : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RESET_WIDTH;
            grid_height_reg <= RESET_HEIGHT;
            death_limit_reg <= RESET_DEATH;
            birth_limit_reg <= RESET_BIRTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[GH_W-1:0];
                CFG_DEATH_LIMIT: death_limit_reg <= cfg_data[LIM_W-1:0];
                CFG_BIRTH_LIMIT: birth_limit_reg <= cfg_data[LIM_W-1:0];
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    cag_row_gen #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_gen (
        .older_row   (older_reg),
        .newer_row   (newer_reg),
        .cur_row     (row_cells),
        .width_eff   (width_eff),
        .death_limit (death_limit_reg),
        .birth_limit (birth_limit_reg),
        .first_row   (row_cnt_reg == CNT_W'(1)),
        .next_row    (gen_row),
        .mask        (mask)
    );

    always_comb
    begin
        older_next   = older_reg;
        newer_next   = newer_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            older_next   = newer_reg;
            newer_next   = row_cells & mask;
            row_cnt_next = last ? CNT_W'(0) : cnt_plus1[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg   <= '0;
            newer_reg   <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_comb
    begin
        first_meta.row_number  = ROWNUM_W'(row_cnt_reg - CNT_W'(1));
        first_meta.last_of_run = ~last;
        first_meta.frame_end   = 1'b0;
        last_meta.row_number   = ROWNUM_W'(height_eff - (CNT_W+1)'(1));
        last_meta.last_of_run  = 1'b1;
        last_meta.frame_end    = 1'b1;
        // the bottom border beat goes first when the row made no regular beat
        a_row  = has_first ? gen_row : mask;
        a_meta = has_first ? first_meta : last_meta;
    end

    cag_out_queue #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .a_row     (a_row),
        .a_meta    (a_meta),
        .b_row     (mask),
        .b_meta    (last_meta),
        .out_stall (result_stall),
        .out_valid (result_valid),
        .head_row  (next_row_cells),
        .head_meta (head_meta),
        .level     (level)
    );

    assign row_number  = head_meta.row_number;
    assign last_of_run = head_meta.last_of_run;
    assign frame_end   = head_meta.frame_end;

endmodule

`default_nettype wire

// File: rtl/core/cag_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "cave_automaton_generation_defines.svh"

module cag_checker #(
    parameter int MAX_WIDTH = cag_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           result_valid,
    input  wire logic                           result_stall,
    input  wire logic [MAX_WIDTH-1:0]           next_row_cells,
    input  wire logic [cag_pkg::ROWNUM_W-1:0]   row_number,
    input  wire logic                           last_of_run,
    input  wire logic                           frame_end
);

    // the bottom border beat always closes its run
    `CAG_ASSERT_NOW(a_frame_end_closes_run, clk, rst_n, result_valid && frame_end, last_of_run)

    // column zero is border and always rock
    `CAG_ASSERT_NOW(a_left_border_rock, clk, rst_n, result_valid, next_row_cells[0])

    // row zero is the top border, never the frame's last beat
    `CAG_ASSERT_NOW(a_top_not_end, clk, rst_n, result_valid && row_number == '0, !frame_end)

    `CAG_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(next_row_cells) && $stable(row_number))

endmodule

bind cave_automaton_generation cag_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_cag_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .next_row_cells (next_row_cells),
    .row_number     (row_number),
    .last_of_run    (last_of_run),
    .frame_end      (frame_end)
);

`default_nettype wire

// File: bench/cave_automaton_generation_checker.sv
`timescale 1ns / 1ps

module cave_automaton_generation_checker #(
    parameter int MAX_WIDTH  = cag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cag_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cag_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           row_valid,
    input  logic                           row_stall,
    input  logic [MAX_WIDTH-1:0]           row_cells,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  logic [MAX_WIDTH-1:0]           next_row_cells,
    input  logic [cag_pkg::ROWNUM_W-1:0]   row_number,
    input  logic                           last_of_run,
    input  logic                           frame_end,
    output int                             fail_count,
    output int                             pending,
    output int                             beats_checked
);
    import cag_pkg::*;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] cells;
        logic [ROWNUM_W-1:0]  number;
        logic                 run_end;
        logic                 grid_end;
    } grid_row_t;

    grid_row_t expected_rows[$];

    logic [GW_W-1:0]      grid_width;
    logic [GH_W-1:0]      grid_height;
    logic [LIM_W-1:0]     death_limit;
    logic [LIM_W-1:0]     birth_limit;
    logic [MAX_WIDTH-1:0] older_row;
    logic [MAX_WIDTH-1:0] newer_row;
    logic [ROWNUM_W-1:0]  row_ctr;

    function automatic logic [MAX_WIDTH-1:0] evolve_row(input logic [MAX_WIDTH-1:0] above,
                                                       input logic [MAX_WIDTH-1:0] mid,
                                                       input logic [MAX_WIDTH-1:0] below,
                                                       input int w);
        logic [MAX_WIDTH-1:0] next_cells;
        int count;
        next_cells = '0;
        next_cells[0] = 1'b1;
        next_cells[w-1] = 1'b1;
        for (int x = 1; x + 1 < w; x++)
        begin
            count = int'(above[x-1]) + int'(above[x]) + int'(above[x+1])
                  + int'(mid[x-1]) + int'(mid[x+1])
                  + int'(below[x-1]) + int'(below[x]) + int'(below[x+1]);
            if (mid[x])
                next_cells[x] = (count >= int'(death_limit));
            else
                next_cells[x] = (count > int'(birth_limit));
        end
        return next_cells;
    endfunction

    task automatic queue_expected(input grid_row_t beat);
        expected_rows = {expected_rows, beat};
    endtask

    // One accepted row: at most two beats, the second closes the frame.
    task automatic take_row(input logic [MAX_WIDTH-1:0] raw);
        int w;
        int h;
        int r;
        logic last;
        logic [MAX_WIDTH-1:0] mask;
        logic [MAX_WIDTH-1:0] cur;
        grid_row_t beat;
        w = int'(grid_width);
        if (w < int'(MIN_WIDTH)) w = int'(MIN_WIDTH);
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(grid_height);
        if (h < int'(MIN_HEIGHT)) h = int'(MIN_HEIGHT);
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (h > COUNTER_SPAN) h = COUNTER_SPAN;
        if (w >= MAX_WIDTH)
            mask = '1;
        else
            mask = (MAX_WIDTH'(1) << w) - 1'b1;
        cur = raw & mask;
        r = int'(row_ctr);
        last = (r + 1 >= h);
        if (r >= 1)
        begin
            if (r == 1)
                beat.cells = mask;
            else
                beat.cells = evolve_row(older_row & mask, newer_row & mask, cur, w) & mask;
            beat.number = ROWNUM_W'(r - 1);
            beat.run_end = !last;
            beat.grid_end = 1'b0;
            queue_expected(beat);
        end
        if (last)
        begin
            beat.cells = mask;
            beat.number = ROWNUM_W'(h - 1);
            beat.run_end = 1'b1;
            beat.grid_end = 1'b1;
            queue_expected(beat);
        end
        older_row = newer_row;
        newer_row = cur;
        row_ctr = last ? '0 : ROWNUM_W'(r + 1);
    endtask

    task automatic check_beat();
        grid_row_t want;
        beats_checked++;
        if (expected_rows.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected beat row %0d cells %h last %b end %b",
                         $time, row_number, next_row_cells, last_of_run, frame_end);
        end
        else
        begin
            want = expected_rows.pop_front();
            if (want.cells !== next_row_cells || want.number !== row_number ||
                want.run_end !== last_of_run || want.grid_end !== frame_end)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("%0t: mismatch expected row %0d cells %h last %b end %b",
                             $time, want.number, want.cells, want.run_end, want.grid_end);
                    $display("%0t:          actual   row %0d cells %h last %b end %b",
                             $time, row_number, next_row_cells, last_of_run, frame_end);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width = RESET_WIDTH;
            grid_height = RESET_HEIGHT;
            death_limit = RESET_DEATH;
            birth_limit = RESET_BIRTH;
            older_row = '0;
            newer_row = '0;
            row_ctr = '0;
            expected_rows.delete();
            fail_count = 0;
            pending = 0;
            beats_checked = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_beat();
            // a row taken on the same edge as a register write still sees the old value
            if (row_valid && !row_stall)
                take_row(row_cells);
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GRID_WIDTH:  grid_width = cfg_data[GW_W-1:0];
                    CFG_GRID_HEIGHT: grid_height = cfg_data[GH_W-1:0];
                    CFG_DEATH_LIMIT: death_limit = cfg_data[LIM_W-1:0];
                    CFG_BIRTH_LIMIT: birth_limit = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            pending = expected_rows.size();
        end
    end

endmodule

// File: bench/cave_automaton_generation_tb.sv
`timescale 1ns / 1ps

module cave_automaton_generation_tb;
    import cag_pkg::*;

    localparam int ROW_W          = DEF_MAX_WIDTH;
    localparam int HOLD_CYCLES    = 200;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 10;
    localparam int ROWS_PER_PHASE = 125;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  row_valid = 1'b0;
    logic                  row_stall;
    logic [ROW_W-1:0]      row_cells = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [ROW_W-1:0]      next_row_cells;
    logic [ROWNUM_W-1:0]   row_number;
    logic                  last_of_run;
    logic                  frame_end;

    int fail_count;
    int pending;
    int beats_checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int rows_sent = 0;
    int cycles = 0;

    always #4 clk = ~clk;

    cave_automaton_generation uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .row_valid      (row_valid),
        .row_stall      (row_stall),
        .row_cells      (row_cells),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .next_row_cells (next_row_cells),
        .row_number     (row_number),
        .last_of_run    (last_of_run),
        .frame_end      (frame_end)
    );

    cave_automaton_generation_checker row_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .row_valid      (row_valid),
        .row_stall      (row_stall),
        .row_cells      (row_cells),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .next_row_cells (next_row_cells),
        .row_number     (row_number),
        .last_of_run    (last_of_run),
        .frame_end      (frame_end),
        .fail_count     (fail_count),
        .pending        (pending),
        .beats_checked  (beats_checked)
    );

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return a & b;
            3: return a | b;
            default: return a;
        endcase
    endfunction

    // Called and returns at a falling edge.
    task automatic send_row(input logic [ROW_W-1:0] cells);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            row_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_valid <= 1'b1;
        row_cells <= cells;
        @(posedge clk);
        while (row_stall)
            @(posedge clk);
        rows_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        row_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // a first row of a frame leaves nothing pending to wait on
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height,
                             input logic [CFG_DATA_W-1:0] death,
                             input logic [CFG_DATA_W-1:0] birth);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data <= width;
        @(negedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data <= height;
        @(negedge clk);
        cfg_index <= CFG_DEATH_LIMIT;
        cfg_data <= death;
        @(negedge clk);
        cfg_index <= CFG_BIRTH_LIMIT;
        cfg_data <= birth;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        logic [CFG_DATA_W-1:0] d_val;
        logic [CFG_DATA_W-1:0] b_val;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults, frame left open
        send_row('0);
        send_row('1);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        send_row(64'h5555_5555_5555_5555);
        // smallest grid; counter already past the new last row
        configure(13'd3, 13'd3, 13'd0, 13'd8);
        send_row('1);
        send_row('1);
        send_row('0);
        send_row(64'h0000_0000_0000_0002);
        // width and height below range saturate, limits above eight
        configure(13'd0, 13'd0, 13'd15, 13'd15);
        send_row(random_row());
        send_row(random_row());
        send_row(random_row());
        // width above range
        configure(13'd127, 13'd5, 13'd9, 13'd8);
        send_row('1);
        send_row(64'hFFFF_0000_FFFF_0000);
        send_row('0);
        send_row('1);
        send_row(64'h8000_0000_0000_0001);
        // only bits beyond the width set on one row
        configure(13'd10, 13'd4, 13'd8, 13'd0);
        send_row('0);
        send_row(64'h0000_0000_0000_02AA);
        send_row(64'hFFFF_FFFF_FFFF_FC00);
        send_row('1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(9))
                0: w_val = 13'd3;
                1: w_val = 13'd64;
                2: w_val = 13'($urandom_range(127));
                default: w_val = 13'($urandom_range(3, 64));
            endcase
            case ($urandom_range(9))
                0: h_val = 13'($urandom_range(2));
                1: h_val = $urandom_range(1) ? 13'd8191 : 13'd4096;
                2: h_val = 13'($urandom_range(4, 200));
                default: h_val = 13'($urandom_range(3, 12));
            endcase
            d_val = ($urandom_range(9) == 0) ? 13'($urandom_range(9, 15))
                                             : 13'($urandom_range(8));
            b_val = ($urandom_range(9) == 0) ? 13'($urandom_range(9, 15))
                                             : 13'($urandom_range(8));
            if (phase == 0)
            begin
                w_val = 13'd64;
                d_val = 13'd4;
                b_val = 13'd4;
            end
            configure(w_val, h_val, d_val, b_val);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            // back the block up against a receiver that stops taking beats
            if (phase == 2)
                hold_req++;
            for (int i = 0; i < ROWS_PER_PHASE; i++)
            begin
                if (phase == 5 && i == ROWS_PER_PHASE / 2)
                    drain();
                send_row(random_row());
            end
        end

        drain();
        repeat (8) @(negedge clk);
        $display("covered %0d rows and %0d result beats over %0d random setups",
                 rows_sent, beats_checked, RANDOM_PHASES);
        $display("widths 3..64 and out of range, heights 3..4096, limits 0..15, long stall");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cag_pkg.sv
rtl/core/cag_lane.sv
rtl/core/cag_row_gen.sv
rtl/core/cag_out_queue.sv
rtl/core/cave_automaton_generation.sv
rtl/core/cag_checker.sv
bench/cave_automaton_generation_checker.sv
bench/cave_automaton_generation_tb.sv
